>>> src/edmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edmf_pkg
// Shared types, constants and register codes of the echo distance median
// filter.
// ----------------------------------------------------------------------------
package edmf_pkg;

  // field widths
  localparam int SIDX_W = 2;
  localparam int ECHO_W = 12;
  localparam int GAIN_W = 16;
  localparam int DIST_W = 16;
  localparam int CFG_W  = 64;
  localparam int CIDX_W = 2;

  // default sensor count and the fixed window length
  localparam int SENSORS_DEF = 4;
  localparam int MAX_SENSORS = 4;
  localparam int WINDOW      = 5;
  localparam int SLOT_W      = $clog2(WINDOW);
  localparam int RANK_W      = $clog2(WINDOW + 1);

  // conversion: distance = echo * gain * 100 / (58 * 2^14)
  localparam int US_PER_CM    = 58;
  localparam int UNITS_PER_CM = 100;
  localparam int GAIN_FRAC    = 14;
  localparam int PROD_W       = ECHO_W + GAIN_W;
  localparam int SCALED_W     = PROD_W + 7;
  localparam int NUM_W        = SCALED_W - GAIN_FRAC;
  localparam int RECIP_SHIFT  = 27;
  localparam longint RECIP_MUL = ((64'd1 << RECIP_SHIFT) + US_PER_CM - 1) / US_PER_CM;
  localparam int RECIP_W      = 22;
  localparam int QPROD_W      = NUM_W + RECIP_W;

  // register reset values
  localparam logic [CFG_W-1:0] GAIN_RESET = 64'd4611756387619323776;
  localparam logic [CFG_W-1:0] MIN_RESET  = '0;
  localparam logic [CFG_W-1:0] MAX_RESET  = '1;

  typedef enum logic [CIDX_W-1:0] {
    CFG_GAIN = 2'd0,
    CFG_MIN  = 2'd1,
    CFG_MAX  = 2'd2
  } edmf_cfg_idx_t;

  typedef logic [DIST_W-1:0] edmf_dist_t;
  typedef edmf_dist_t [WINDOW-1:0] edmf_win_t;

  // per-stage load enables of the conversion pipe
  typedef struct packed {
    logic load_s1;
    logic load_s2;
    logic load_s3;
  } edmf_adv_t;

endpackage

>>> src/edmf_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edmf_convert
// Three-stage echo time to distance conversion: gain multiply, scale by 100
// with removal of the Q2.14 fraction, then division by 58 via reciprocal.
// ----------------------------------------------------------------------------
module edmf_convert import edmf_pkg::*; (
  input  logic              clk,
  input  edmf_adv_t         adv,
  input  logic [ECHO_W-1:0] echo_us,
  input  logic [GAIN_W-1:0] gain,
  output edmf_dist_t        conv_dist
);

  logic [PROD_W-1:0]   prod;
  logic [NUM_W-1:0]    num;
  logic [SCALED_W-1:0] scaled;
  logic [QPROD_W-1:0]  qprod;

  assign scaled = SCALED_W'(prod) * SCALED_W'(UNITS_PER_CM);
  assign qprod  = QPROD_W'(num) * QPROD_W'(RECIP_MUL);

  always_ff @(posedge clk) begin
    if (adv.load_s1) begin
      prod <= PROD_W'(echo_us) * PROD_W'(gain);
    end
    if (adv.load_s2) begin
      num <= scaled[SCALED_W-1:GAIN_FRAC];
    end
    // reciprocal is exact over the whole numerator range; the quotient
    // never exceeds 28241, so the upper bits hold it without saturation
    if (adv.load_s3) begin
      conv_dist <= qprod[QPROD_W-1:RECIP_SHIFT];
    end
  end

endmodule

>>> src/edmf_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edmf_median
// Median of a five-entry window by rank counting: every entry is compared
// with every other, ties broken by position, and the middle rank is chosen.
// ----------------------------------------------------------------------------
module edmf_median import edmf_pkg::*; (
  input  edmf_win_t  win,
  output edmf_dist_t median
);

  logic [RANK_W-1:0] rank [WINDOW];

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i) begin
          if ((win[j] < win[i]) || ((j < i) && (win[j] == win[i]))) begin
            rank[i] = rank[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  // ranks form a permutation, so exactly one entry sits in the middle
  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == RANK_W'(WINDOW / 2)) begin
        median = win[i];
      end
    end
  end

endmodule

>>> src/echo_distance_median_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_distance_median_filter
// Per-sensor echo to distance conversion followed by a five-entry running
// median with min/max clamp.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while out_ready does not stall, set by
//   the four-register pipeline (gain multiply, scale, reciprocal divide,
//   history update with median)
// the history read-modify-write sits in the last stage alone, so beats for
//   the same sensor follow each other without a hazard
// reset (rst, synchronous): pipeline emptied, histories and write slots
//   cleared to zero, gain/min/max registers back to their defaults
module echo_distance_median_filter import edmf_pkg::*; #(
  parameter int SENSORS = SENSORS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [SIDX_W-1:0] sensor_index,
  input  logic [ECHO_W-1:0] echo_us,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SIDX_W-1:0] sensor_id,
  output logic [DIST_W-1:0] distance,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic [CFG_W-1:0] gain_word;
  logic [CFG_W-1:0] min_word;
  logic [CFG_W-1:0] max_word;

  edmf_win_t         history    [SENSORS];
  logic [SLOT_W-1:0] write_slot [SENSORS];

  logic v1, v2, v3;
  logic [SIDX_W-1:0] sid1, sid2, sid3;
  logic adv4;
  edmf_adv_t adv;

  logic [GAIN_W-1:0] gain_sel;
  edmf_dist_t        dist3;

  logic              ok3;
  edmf_win_t         row;
  edmf_win_t         row_next;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  edmf_dist_t        med;
  edmf_dist_t        hi;
  edmf_dist_t        lo;
  edmf_dist_t        clamped;
  logic              hist_we;

  // configuration: the user writes it only while idle; the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_word <= GAIN_RESET;
      min_word  <= MIN_RESET;
      max_word  <= MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAIN: gain_word <= cfg_data;
        CFG_MIN:  min_word  <= cfg_data;
        CFG_MAX:  max_word  <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its contents move on
  assign adv4        = !out_valid || out_ready;
  assign adv.load_s3 = !v3 || adv4;
  assign adv.load_s2 = !v2 || adv.load_s3;
  assign adv.load_s1 = !v1 || adv.load_s2;
  assign in_ready    = adv.load_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv.load_s1) v1 <= in_valid;
      if (adv.load_s2) v2 <= v1;
      if (adv.load_s3) v3 <= v2;
      if (adv4)        out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.load_s1) sid1 <= sensor_index;
    if (adv.load_s2) sid2 <= sid1;
    if (adv.load_s3) sid3 <= sid2;
  end

  assign gain_sel = gain_word[sensor_index*GAIN_W +: GAIN_W];

  edmf_convert u_convert (
    .clk       (clk),
    .adv       (adv),
    .echo_us   (echo_us),
    .gain      (gain_sel),
    .conv_dist (dist3)
  );

  // last stage: insert the new distance into the sensor's window
  assign ok3 = {1'b0, sid3} < 3'(SENSORS);

  always_comb begin
    row  = '0;
    slot = '0;
    for (int i = 0; i < SENSORS; i++) begin
      if (sid3 == SIDX_W'(i)) begin
        row  = history[i];
        slot = write_slot[i];
      end
    end
    if (slot >= SLOT_W'(WINDOW)) begin
      slot = '0;
    end
    row_next       = row;
    row_next[slot] = dist3;
    slot_next      = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + SLOT_W'(1);
  end

  edmf_median u_median (
    .win    (row_next),
    .median (med)
  );

  assign hi = max_word[sid3*DIST_W +: DIST_W];
  assign lo = min_word[sid3*DIST_W +: DIST_W];

  // max first, then min, so min wins when the two cross
  always_comb begin
    clamped = (med > hi) ? hi : med;
    if (clamped < lo) begin
      clamped = lo;
    end
  end

  assign hist_we = adv4 && v3 && ok3;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SENSORS; i++) begin
        history[i]    <= '0;
        write_slot[i] <= '0;
      end
    end else if (hist_we) begin
      for (int i = 0; i < SENSORS; i++) begin
        if (sid3 == SIDX_W'(i)) begin
          history[i]    <= row_next;
          write_slot[i] <= slot_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && v3) begin
      sensor_id <= sid3;
      distance  <= ok3 ? clamped : '0;
    end
  end

  // the output register alone never holds off the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_stage3_reaches_out: assert property (@(posedge clk) disable iff (rst)
    v3 && adv4 |=> out_valid)
    else $error("result lost between last stage and output register");

  a_bad_sensor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ({1'b0, sensor_id} >= 3'(SENSORS)) |-> distance == '0)
    else $error("unknown sensor gave a nonzero distance");

  a_min_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && ({1'b0, sensor_id} < 3'(SENSORS))
      |-> distance >= min_word[sensor_id*DIST_W +: DIST_W])
    else $error("distance below the sensor minimum");

  for (genvar g = 0; g < SENSORS; g++) begin : g_slot_chk
    a_slot_range: assert property (@(posedge clk) disable iff (rst)
      write_slot[g] < SLOT_W'(WINDOW))
      else $error("write slot out of window range");
  end

endmodule

>>> verif/echo_distance_median_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_distance_median_filter_tb
// Drives echo beats through the filter and compares every result beat with a
// local predictor of the gain conversion, the per-sensor ring history and the
// clamped median. Directed tests cover fresh histories, gain and echo
// extremes and the clamps, then random phases under several register
// settings, then a long receiver hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module echo_distance_median_filter_tb;
  import edmf_pkg::*;

  localparam int N_SENSORS = SENSORS_DEF;
  localparam int LATENCY   = 4;
  localparam int MAX_GAP   = 17;
  localparam int HOLD_OFF  = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASES    = 12;
  localparam int PHASE_ITEMS = 42;
  localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [SIDX_W-1:0] sid;
    edmf_dist_t        dist_val;
  } filtered_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [SIDX_W-1:0] sensor_index;
  logic [ECHO_W-1:0] echo_us;
  logic              out_valid;
  logic              out_ready;
  logic [SIDX_W-1:0] sensor_id;
  logic [DIST_W-1:0] distance;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  // predictor state
  logic [CFG_W-1:0] gain_m;
  logic [CFG_W-1:0] min_m;
  logic [CFG_W-1:0] max_m;
  edmf_dist_t       history_m [MAX_SENSORS][WINDOW];
  int               slot_m [MAX_SENSORS];

  filtered_t filtered_q [$];
  int        errors = 0;
  int        stall_cycles = 0;
  bit        idle_on = 1'b1;
  int        hold_req = 0;

  echo_distance_median_filter #(.SENSORS(N_SENSORS)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sensor_index(sensor_index), .echo_us(echo_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .sensor_id(sensor_id), .distance(distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // conversion, history update and clamped median for one echo
  function automatic filtered_t filter_echo(logic [SIDX_W-1:0] s, logic [ECHO_W-1:0] e);
    filtered_t  r;
    logic [63:0] num;
    logic [63:0] q;
    edmf_dist_t win [WINDOW];
    edmf_dist_t t;
    edmf_dist_t med;
    int         slot;
    int         i;
    int         j;
    r.sid      = s;
    r.dist_val = '0;
    if (s >= N_SENSORS) return r;
    num = 64'(e) * 64'(gain_m[s*GAIN_W +: GAIN_W]) * 64'(UNITS_PER_CM);
    q   = num / (64'(US_PER_CM) << GAIN_FRAC);
    if (q > 64'hFFFF) q = 64'hFFFF;
    slot = slot_m[s];
    if (slot >= WINDOW) slot = 0;
    history_m[s][slot] = q[DIST_W-1:0];
    slot_m[s] = (slot + 1) % WINDOW;
    for (i = 0; i < WINDOW; i++) win[i] = history_m[s][i];
    for (i = 1; i < WINDOW; i++) begin
      t = win[i];
      j = i - 1;
      while (j >= 0 && win[j] > t) begin
        win[j+1] = win[j];
        j--;
      end
      win[j+1] = t;
    end
    med = win[WINDOW/2];
    if (med > max_m[s*DIST_W +: DIST_W]) med = max_m[s*DIST_W +: DIST_W];
    if (med < min_m[s*DIST_W +: DIST_W]) med = min_m[s*DIST_W +: DIST_W];
    r.dist_val = med;
    return r;
  endfunction

  // one echo beat; in_valid stays up when the next beat follows at once
  task automatic send_echo(input logic [SIDX_W-1:0] s, input logic [ECHO_W-1:0] e);
    int gap;
    filtered_t exp_beat;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sensor_index <= s;
    echo_us      <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_beat = filter_echo(s, e);
    filtered_q.insert(filtered_q.size(), exp_beat);
  endtask

  // drop in_valid, wait for every result, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (filtered_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GAIN: gain_m = data;
      CFG_MIN:  min_m  = data;
      CFG_MAX:  max_m  = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] lo,
                           input logic [CFG_W-1:0] hi);
    write_reg(CFG_GAIN, g);
    write_reg(CFG_MIN, lo);
    write_reg(CFG_MAX, hi);
  endtask

  // untouched entries read as zero, so the median lags the first writes
  task automatic test_fresh_history();
    send_echo(2'd0, 12'hFFF);
    send_echo(2'd0, 12'hFFF);
    send_echo(2'd0, 12'hFFF);
    send_echo(2'd1, 12'h000);
    send_echo(2'd3, 12'hFFF);
    send_echo(2'd2, 12'h800);
    settle();
  endtask

  task automatic test_conversion_extremes();
    int i;
    write_reg(CFG_GAIN, '1);
    for (i = 0; i < 4; i++) send_echo(2'd2, 12'hFFF);
    send_echo(2'd1, 12'h001);
    settle();
    write_reg(CFG_GAIN, '0);
    send_echo(2'd3, 12'hFFF);
    send_echo(2'd0, 12'h7FF);
    settle();
    write_reg(CFG_GAIN, GAIN_RESET);
  endtask

  task automatic test_clamps();
    write_reg(CFG_MAX, {4{16'd1000}});
    send_echo(2'd0, 12'hFFF);
    send_echo(2'd3, 12'hFFF);
    settle();
    // minimum above maximum: the minimum is applied last and wins
    write_reg(CFG_MIN, {4{16'd3000}});
    send_echo(2'd0, 12'hFFF);
    send_echo(2'd1, 12'h000);
    send_echo(2'd2, 12'h000);
    settle();
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    write_all(GAIN_RESET, MIN_RESET, MAX_RESET);
    send_echo(2'd1, 12'h5A5);
    settle();
  endtask

  task automatic test_random_phases();
    int p;
    int k;
    int sent;
    int burst;
    int base;
    int v;
    logic [SIDX_W-1:0] s;
    logic [CFG_W-1:0] g;
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    for (p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          g = {$urandom, $urandom};
          for (k = 0; k < MAX_SENSORS; k++) begin
            lo[k*16 +: 16] = 16'($urandom_range(0, 2000));
            hi[k*16 +: 16] = 16'($urandom_range(3000, 65535));
          end
        end
        1: begin
          case ((p / 4) % 3)
            0: begin g = '1; lo = '0; hi = '1; end
            1: begin g = '0; lo = '1; hi = '1; end
            default: begin g = {4{16'h4000}}; lo = '0; hi = '0; end
          endcase
        end
        2: begin
          for (k = 0; k < MAX_SENSORS; k++) begin
            g[k*16 +: 16]  = 16'($urandom_range(16'h3000, 16'h5000));
            lo[k*16 +: 16] = 16'($urandom_range(0, 3000));
            hi[k*16 +: 16] = 16'($urandom_range(2000, 6000));
          end
        end
        default: begin
          g  = {$urandom, $urandom};
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
          write_reg(CFG_UNUSED, {$urandom, $urandom});
        end
      endcase
      write_all(g, lo, hi);
      idle_on = (p % 3 != 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          // burst on one sensor around a level, with the odd spike
          s     = SIDX_W'($urandom_range(0, MAX_SENSORS - 1));
          base  = $urandom_range(0, 4095);
          burst = $urandom_range(5, 8);
          for (k = 0; k < burst; k++) begin
            if ($urandom_range(0, 4) == 0) v = $urandom_range(0, 4095);
            else v = base + int'($urandom_range(0, 200)) - 100;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            send_echo(s, 12'(v));
          end
          sent += burst;
        end else begin
          send_echo(SIDX_W'($urandom_range(0, MAX_SENSORS - 1)),
                    ECHO_W'($urandom_range(0, 4095)));
          sent++;
        end
      end
      settle();
    end
    idle_on = 1'b1;
  endtask

  // receiver stalls for a long stretch while beats keep coming
  task automatic test_backpressure();
    int i;
    write_all({4{16'h4000}}, {$urandom, $urandom} & {4{16'h0FFF}}, '1);
    idle_on  = 1'b0;
    hold_req = HOLD_OFF;
    for (i = 0; i < 60; i++)
      send_echo(SIDX_W'($urandom_range(0, MAX_SENSORS - 1)),
                ECHO_W'($urandom_range(0, 4095)));
    settle();
    idle_on = 1'b1;
  endtask

  initial begin : receiver
    int wait_n;
    int hold_n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        hold_n   = hold_req;
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (hold_n) @(posedge clk);
      end
      wait_n = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    filtered_t want;
    if (!rst && out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected result beat sensor_id %0d distance %0d",
                 $time, sensor_id, distance);
        errors++;
      end else begin
        want = filtered_q.pop_front();
        if (sensor_id !== want.sid) begin
          $display("%0t: sensor_id expected %0d actual %0d", $time, want.sid, sensor_id);
          errors++;
        end
        if (distance !== want.dist_val) begin
          $display("%0t: distance expected %0d actual %0d (sensor %0d)",
                   $time, want.dist_val, distance, want.sid);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, filtered_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int i;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    sensor_index <= '0;
    echo_us      <= '0;
    out_ready    <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    gain_m = GAIN_RESET;
    min_m  = MIN_RESET;
    max_m  = MAX_RESET;
    for (i = 0; i < MAX_SENSORS; i++) begin
      slot_m[i] = 0;
      for (int k = 0; k < WINDOW; k++) history_m[i][k] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fresh_history();
    test_conversion_extremes();
    test_clamps();
    test_random_phases();
    test_backpressure();

    settle();
    repeat (LATENCY * 2) @(posedge clk);
    if (errors == 0 && filtered_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
